### design/pca_pkg.sv
`default_nettype none
package pca_pkg;

  localparam int TIMER_W = 16;
  localparam int SEQ_W   = 32;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_SRC = 4;
  localparam int SRC_W   = 2;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;

  localparam logic [CFG_W-1:0] MIN_GAP_RST   = CFG_W'(100);
  localparam logic [CFG_W-1:0] HOLDOFF_RST   = CFG_W'(1500);
  localparam logic [CFG_W-1:0] KEEPALIVE_RST = CFG_W'(1500);
  localparam logic [SEQ_W-1:0] SEQ_RST       = SEQ_W'(2);
  localparam logic [TIMER_W-1:0] TIMER_MAX   = {TIMER_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_GAP   = 2'd0,
    REG_HOLDOFF   = 2'd1,
    REG_KEEPALIVE = 2'd2
  } reg_idx_t;

  typedef enum logic {
    CMD_POST = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_URGENT    = 2'd0,
    KIND_NORMAL    = 2'd1,
    KIND_KEEPALIVE = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [SRC_W-1:0] src;
    logic [SEQ_W-1:0] seq;
  } res_t;

  function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
    sat_inc = (v == TIMER_MAX) ? v : v + TIMER_W'(1);
  endfunction

endpackage
`default_nettype wire

### design/priority_command_arbiter_holdoff.sv
`default_nettype none
// Channel  Dir  tdata (low bit up)                  tuser
// in_      in   source[1:0], urgent[2], zero pad    cmd (0 post, 1 tick)
// out_     out  granted_source[1:0], sequence[33:2] kind (0 urgent, 1 normal, 2 keepalive)
// cfg_     in   wdata[15:0] to register cfg_index   -
//
// One request per cycle while in_tready is high: a post or tick is resolved combinationally; its result,
// if any, is registered at the accepting edge into the output register, or into the skid entry while that is held.
// A two-entry output (register plus skid) lets requests flow while a result waits;
// in_tready drops only when both entries hold results.
// Synchronous active-low reset: slots empty, timers zero, sequence 2, config defaults.
module priority_command_arbiter_holdoff (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [pca_pkg::IN_DATA_W-1:0]    in_tdata,   // source[1:0], urgent[2]
  input  wire logic                             in_tuser,   // cmd
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [pca_pkg::OUT_DATA_W-1:0]        out_tdata,  // granted_source, sequence
  output logic [1:0]                            out_tuser,  // kind
  input  wire logic                             cfg_wr_en,
  input  wire logic [pca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pca_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int NS = pca_pkg::NUM_SRC;

  logic [pca_pkg::CFG_W-1:0]   min_gap_r, holdoff_r, keepalive_r;
  logic [NS-1:0]               slot_valid_r, slot_valid_nxt;
  logic [NS-1:0]               slot_urg_r, slot_urg_nxt;
  logic [pca_pkg::TIMER_W-1:0] since_any_r, since_any_nxt, any_inc;
  logic [pca_pkg::TIMER_W-1:0] since_src_r [NS-1];
  logic [pca_pkg::TIMER_W-1:0] since_src_nxt [NS-1];
  logic [pca_pkg::TIMER_W-1:0] src_inc [NS-1];
  logic [pca_pkg::SEQ_W-1:0]   seq_r, seq_nxt;

  pca_pkg::res_t out_r, skid_r, res;
  logic          out_v_r, skid_v_r, res_v;

  logic                      in_fire, out_fire, grant_fire;
  logic [pca_pkg::SRC_W-1:0] in_src, urg_idx, norm_idx;
  logic                      in_urg;
  logic [NS-1:0]             urg_vec, norm_vec;
  logic [NS-2:0]             quiet;
  logic                      all_quiet;

  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_v_r && out_tready;
  assign in_tready = !skid_v_r;
  assign in_src    = in_tdata[pca_pkg::SRC_W-1:0];
  assign in_urg    = in_tdata[pca_pkg::SRC_W];

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = pca_pkg::OUT_DATA_W'({out_r.seq, out_r.src});

  always_comb begin
    any_inc = pca_pkg::sat_inc(since_any_r);
    for (int k = 0; k < NS - 1; k++) begin
      src_inc[k] = pca_pkg::sat_inc(since_src_r[k]);
      quiet[k]   = src_inc[k] > holdoff_r;
    end
    urg_vec   = slot_valid_r & slot_urg_r;
    all_quiet = 1'b1;
    for (int s = 0; s < NS; s++) begin
      norm_vec[s] = slot_valid_r[s] && all_quiet;
      if (s < NS - 1) all_quiet = all_quiet && quiet[s];
    end
    // first set bit wins: scan from the top so the lowest index overwrites
    urg_idx  = '0;
    norm_idx = '0;
    for (int s = NS - 1; s >= 0; s--) begin
      if (urg_vec[s])  urg_idx  = pca_pkg::SRC_W'(s);
      if (norm_vec[s]) norm_idx = pca_pkg::SRC_W'(s);
    end
  end

  always_comb begin
    slot_valid_nxt = slot_valid_r;
    slot_urg_nxt   = slot_urg_r;
    since_any_nxt  = since_any_r;
    since_src_nxt  = since_src_r;
    seq_nxt        = seq_r;
    res_v          = 1'b0;
    grant_fire     = 1'b0;
    res.kind       = pca_pkg::KIND_KEEPALIVE;
    res.src        = '0;
    res.seq        = seq_r;
    if (in_fire) begin
      if (in_tuser == pca_pkg::CMD_POST) begin
        slot_valid_nxt[in_src] = 1'b1;
        slot_urg_nxt[in_src]   = in_urg;
      end else begin
        since_any_nxt = any_inc;
        since_src_nxt = src_inc;
        if (any_inc >= min_gap_r) begin
          priority if (|urg_vec) begin
            res_v          = 1'b1;
            grant_fire     = 1'b1;
            res.kind       = pca_pkg::KIND_URGENT;
            res.src        = urg_idx;
            res.seq        = '0;
            seq_nxt        = pca_pkg::SEQ_RST;
            since_any_nxt  = '0;
            slot_valid_nxt = '0;
            slot_urg_nxt   = '0;
          end else if (|norm_vec) begin
            res_v          = 1'b1;
            grant_fire     = 1'b1;
            res.kind       = pca_pkg::KIND_NORMAL;
            res.src        = norm_idx;
            seq_nxt        = seq_r + pca_pkg::SEQ_W'(1);
            since_any_nxt  = '0;
            // automatic source has no quiet timer
            if (norm_idx != pca_pkg::SRC_W'(NS - 1)) begin
              since_src_nxt[norm_idx[pca_pkg::SRC_W-1:0]] = '0;
            end
            slot_valid_nxt = '0;
            slot_urg_nxt   = '0;
          end else if (any_inc > keepalive_r) begin
            res_v         = 1'b1;
            seq_nxt       = seq_r + pca_pkg::SEQ_W'(1);
            since_any_nxt = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gap_r    <= pca_pkg::MIN_GAP_RST;
      holdoff_r    <= pca_pkg::HOLDOFF_RST;
      keepalive_r  <= pca_pkg::KEEPALIVE_RST;
      slot_valid_r <= '0;
      slot_urg_r   <= '0;
      since_any_r  <= '0;
      for (int k = 0; k < NS - 1; k++) since_src_r[k] <= '0;
      seq_r        <= pca_pkg::SEQ_RST;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          pca_pkg::REG_MIN_GAP:   min_gap_r   <= cfg_wdata;
          pca_pkg::REG_HOLDOFF:   holdoff_r   <= cfg_wdata;
          pca_pkg::REG_KEEPALIVE: keepalive_r <= cfg_wdata;
          default: ;
        endcase
      end
      slot_valid_r <= slot_valid_nxt;
      slot_urg_r   <= slot_urg_nxt;
      since_any_r  <= since_any_nxt;
      since_src_r  <= since_src_nxt;
      seq_r        <= seq_nxt;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!out_v_r || out_fire) begin
        if (skid_v_r) begin
          out_v_r  <= 1'b1;
          skid_v_r <= res_v;
        end else begin
          out_v_r  <= res_v;
        end
      end else if (res_v) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_fire) begin
      if (skid_v_r) begin
        out_r <= skid_r;
        if (res_v) skid_r <= res;
      end else if (res_v) begin
        out_r <= res;
      end
    end else if (res_v) begin
      skid_r <= res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry holds a result while output register is empty");

  a_grant_clears_slots: assert property (@(posedge clk) disable iff (!rst_n)
    grant_fire |=> slot_valid_r == '0)
    else $error("slots not cleared after a grant");

  a_urgent_seq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == pca_pkg::KIND_URGENT |-> out_tdata[33:2] == '0)
    else $error("urgent grant carries a nonzero sequence");

  a_keepalive_src_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == pca_pkg::KIND_KEEPALIVE |-> out_tdata[1:0] == '0)
    else $error("keepalive carries a source");

  a_urgent_resets_seq: assert property (@(posedge clk) disable iff (!rst_n)
    res_v && res.kind == pca_pkg::KIND_URGENT |=> seq_r == pca_pkg::SEQ_RST)
    else $error("sequence not reset after urgent grant");

endmodule
`default_nettype wire

### verif/priority_command_arbiter_holdoff_test.sv
`default_nettype none
module priority_command_arbiter_holdoff_test;

  localparam logic [pca_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD = 200;
  localparam pca_pkg::res_t NO_RESULT = '0;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [pca_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [pca_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [1:0]                     out_tuser;
  logic                           cfg_wr_en;
  logic [pca_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pca_pkg::CFG_W-1:0]      cfg_wdata;

  priority_command_arbiter_holdoff dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // shadow of the arbiter state and registers
  logic [pca_pkg::CFG_W-1:0]   gap_min;
  logic [pca_pkg::CFG_W-1:0]   quiet_need;
  logic [pca_pkg::CFG_W-1:0]   alive_after;
  logic [3:0]                  slot_full;
  logic [3:0]                  slot_urg;
  logic [pca_pkg::TIMER_W-1:0] idle_all;
  logic [pca_pkg::TIMER_W-1:0] idle_src [3];
  logic [pca_pkg::SEQ_W-1:0]   seq_num;

  pca_pkg::res_t grants_due [$];
  int   errors;
  int   send_calm;
  int   recv_calm;
  bit   stall_request;
  int   quiet_cycles;

  typedef struct packed {
    logic                      is_cfg;
    pca_pkg::cmd_t             cmd;
    logic [1:0]                sel;     // source, or register index for a config row
    logic                      urgent;
    logic [pca_pkg::CFG_W-1:0] wdata;
    logic                      typed;
    pca_pkg::res_t             want;
  } row_t;

  // config rows run only once the block has drained
  row_t plan [$] = '{
    '{1'b1, pca_pkg::CMD_POST, pca_pkg::REG_MIN_GAP,   1'b0, 16'd0, 1'b0, NO_RESULT},
    '{1'b1, pca_pkg::CMD_POST, pca_pkg::REG_HOLDOFF,   1'b0, 16'd0, 1'b0, NO_RESULT},
    '{1'b1, pca_pkg::CMD_POST, pca_pkg::REG_KEEPALIVE, 1'b0, 16'd0, 1'b0, NO_RESULT},
    '{1'b0, pca_pkg::CMD_TICK, 2'd0, 1'b0, 16'd0, 1'b1,
      '{pca_pkg::KIND_KEEPALIVE, 2'd0, 32'd2}},
    '{1'b0, pca_pkg::CMD_POST, 2'd3, 1'b0, 16'd0, 1'b0, NO_RESULT},
    '{1'b0, pca_pkg::CMD_POST, 2'd0, 1'b1, 16'd0, 1'b0, NO_RESULT},
    '{1'b0, pca_pkg::CMD_TICK, 2'd0, 1'b0, 16'd0, 1'b1,
      '{pca_pkg::KIND_URGENT, 2'd0, 32'd0}},
    '{1'b0, pca_pkg::CMD_POST, 2'd2, 1'b0, 16'd0, 1'b0, NO_RESULT},
    '{1'b0, pca_pkg::CMD_TICK, 2'd0, 1'b0, 16'd0, 1'b1,
      '{pca_pkg::KIND_NORMAL, 2'd2, 32'd2}},
    '{1'b0, pca_pkg::CMD_POST, 2'd3, 1'b1, 16'd0, 1'b0, NO_RESULT},
    '{1'b0, pca_pkg::CMD_POST, 2'd1, 1'b1, 16'd0, 1'b0, NO_RESULT},
    '{1'b0, pca_pkg::CMD_TICK, 2'd3, 1'b1, 16'd0, 1'b1,
      '{pca_pkg::KIND_URGENT, 2'd1, 32'd0}},
    '{1'b0, pca_pkg::CMD_POST, 2'd0, 1'b1, 16'd0, 1'b0, NO_RESULT},
    // same source again: the later post replaces the urgent one
    '{1'b0, pca_pkg::CMD_POST, 2'd0, 1'b0, 16'd0, 1'b0, NO_RESULT},
    '{1'b0, pca_pkg::CMD_TICK, 2'd0, 1'b0, 16'd0, 1'b1,
      '{pca_pkg::KIND_NORMAL, 2'd0, 32'd2}},
    '{1'b1, pca_pkg::CMD_POST, pca_pkg::REG_HOLDOFF, 1'b0, 16'hFFFF, 1'b0, NO_RESULT},
    '{1'b0, pca_pkg::CMD_POST, 2'd1, 1'b0, 16'd0, 1'b0, NO_RESULT},
    // gamepad held off, keepalive goes instead and the slot survives
    '{1'b0, pca_pkg::CMD_TICK, 2'd0, 1'b0, 16'd0, 1'b1,
      '{pca_pkg::KIND_KEEPALIVE, 2'd0, 32'd3}},
    '{1'b0, pca_pkg::CMD_POST, 2'd3, 1'b0, 16'd0, 1'b0, NO_RESULT},
    '{1'b0, pca_pkg::CMD_TICK, 2'd1, 1'b0, 16'd0, 1'b1,
      '{pca_pkg::KIND_KEEPALIVE, 2'd0, 32'd4}},
    '{1'b0, pca_pkg::CMD_POST, 2'd0, 1'b0, 16'd0, 1'b0, NO_RESULT},
    '{1'b0, pca_pkg::CMD_TICK, 2'd0, 1'b0, 16'd0, 1'b1,
      '{pca_pkg::KIND_NORMAL, 2'd0, 32'd5}},
    '{1'b1, pca_pkg::CMD_POST, pca_pkg::REG_MIN_GAP,   1'b0, 16'hFFFF, 1'b0, NO_RESULT},
    '{1'b1, pca_pkg::CMD_POST, pca_pkg::REG_KEEPALIVE, 1'b0, 16'hFFFF, 1'b0, NO_RESULT},
    '{1'b0, pca_pkg::CMD_POST, 2'd1, 1'b0, 16'd0, 1'b0, NO_RESULT},
    // unknown index must not touch the min gap
    '{1'b1, pca_pkg::CMD_POST, REG_UNUSED, 1'b0, 16'd0, 1'b0, NO_RESULT},
    '{1'b0, pca_pkg::CMD_TICK, 2'd2, 1'b1, 16'd0, 1'b0, NO_RESULT},
    '{1'b0, pca_pkg::CMD_TICK, 2'd3, 1'b0, 16'd0, 1'b0, NO_RESULT}
  };

  function automatic logic [pca_pkg::TIMER_W-1:0] bump(
      input logic [pca_pkg::TIMER_W-1:0] v);
    return (v == {pca_pkg::TIMER_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) calm_left = $urandom_range(10, 40);
    return $urandom_range(0, 18);
  endfunction

  task automatic arbitrate(input pca_pkg::cmd_t c, input logic [1:0] s, input logic u,
                           output logic made, output pca_pkg::res_t r);
    int   k;
    int   j;
    logic quiet;
    made = 1'b0;
    r = '0;
    if (c == pca_pkg::CMD_POST) begin
      slot_full[s] = 1'b1;
      slot_urg[s] = u;
      return;
    end
    idle_all = bump(idle_all);
    for (k = 0; k < 3; k++) idle_src[k] = bump(idle_src[k]);
    if (idle_all < gap_min) return;
    for (k = 0; k < 4; k++) begin
      if (!made && slot_full[k] && slot_urg[k]) begin
        r = '{pca_pkg::KIND_URGENT, 2'(k), '0};
        seq_num = pca_pkg::SEQ_RST;
        made = 1'b1;
      end
    end
    for (k = 0; k < 4; k++) begin
      quiet = 1'b1;
      for (j = 0; j < k; j++)
        if (idle_src[j] <= quiet_need) quiet = 1'b0;
      if (!made && slot_full[k] && quiet) begin
        r = '{pca_pkg::KIND_NORMAL, 2'(k), seq_num};
        seq_num++;
        if (k < 3) idle_src[k] = '0;
        made = 1'b1;
      end
    end
    if (made) begin
      idle_all = '0;
      slot_full = '0;
      slot_urg = '0;
    end else if (idle_all > alive_after) begin
      r = '{pca_pkg::KIND_KEEPALIVE, 2'd0, seq_num};
      seq_num++;
      idle_all = '0;
      made = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what,
                                 input logic [pca_pkg::SEQ_W-1:0] got,
                                 input logic [pca_pkg::SEQ_W-1:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input pca_pkg::cmd_t c, input logic [1:0] s, input logic u,
                              input int gap, input logic typed,
                              input pca_pkg::res_t want);
    logic made;
    pca_pkg::res_t r;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c;
    in_tdata <= {5'b0, u, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    arbitrate(c, s, u, made, r);
    if (typed) grants_due.push_back(want);
    else if (made) grants_due.push_back(r);
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (grants_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [pca_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pca_pkg::CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      pca_pkg::REG_MIN_GAP:   gap_min = data;
      pca_pkg::REG_HOLDOFF:   quiet_need = data;
      pca_pkg::REG_KEEPALIVE: alive_after = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result checker
  always @(posedge clk) begin
    pca_pkg::res_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (grants_due.size() == 0) begin
        report_mismatch("request with nothing expected, seq", out_tdata[33:2], '0);
      end else begin
        exp_res = grants_due.pop_front();
        if (out_tuser != exp_res.kind)
          report_mismatch("kind", 32'(out_tuser), 32'(exp_res.kind));
        if (out_tdata[1:0] != exp_res.src)
          report_mismatch("granted_source", 32'(out_tdata[1:0]), 32'(exp_res.src));
        if (out_tdata[33:2] != exp_res.seq)
          report_mismatch("sequence", out_tdata[33:2], exp_res.seq);
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("priority_command_arbiter_holdoff_test: FAIL");
        $finish;
      end
    end
  end

  // receiver
  initial begin
    int gap;
    out_tready = 1'b0;
    recv_calm = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall_request) begin
        gap = LONG_HOLD;
        stall_request = 1'b0;
      end else begin
        gap = draw_gap(recv_calm);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    int   phase;
    pca_pkg::cmd_t c;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    errors = 0;
    send_calm = 0;
    stall_request = 1'b0;
    gap_min = pca_pkg::MIN_GAP_RST;
    quiet_need = pca_pkg::HOLDOFF_RST;
    alive_after = pca_pkg::KEEPALIVE_RST;
    slot_full = '0;
    slot_urg = '0;
    idle_all = '0;
    idle_src = '{default: '0};
    seq_num = pca_pkg::SEQ_RST;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].sel, plan[i].wdata);
      end else begin
        send_request(plan[i].cmd, plan[i].sel, plan[i].urgent, draw_gap(send_calm),
                     plan[i].typed, plan[i].want);
      end
    end

    settle();
    write_reg(pca_pkg::REG_KEEPALIVE, 16'hFFFE);
    send_request(pca_pkg::CMD_TICK, 2'd0, 1'b0, 0, 1'b0, NO_RESULT);
    settle();
    write_reg(pca_pkg::REG_HOLDOFF, 16'hFFFE);
    write_reg(pca_pkg::REG_MIN_GAP, 16'd0);
    send_request(pca_pkg::CMD_TICK, 2'd0, 1'b0, 0, 1'b0, NO_RESULT);

    for (phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0: begin
          write_reg(pca_pkg::REG_MIN_GAP, 16'd0);
          write_reg(pca_pkg::REG_HOLDOFF, 16'd0);
          write_reg(pca_pkg::REG_KEEPALIVE, 16'd0);
        end
        1: begin
          // every tick yields a result: fill the output while the receiver sits
          write_reg(pca_pkg::REG_MIN_GAP, 16'd0);
          write_reg(pca_pkg::REG_HOLDOFF, 16'($urandom_range(0, 10)));
          write_reg(pca_pkg::REG_KEEPALIVE, 16'd0);
          stall_request = 1'b1;
        end
        5: begin
          write_reg(pca_pkg::REG_MIN_GAP, 16'($urandom_range(0, 4)));
          write_reg(pca_pkg::REG_HOLDOFF, 16'hFFFF);
          write_reg(pca_pkg::REG_KEEPALIVE, 16'($urandom_range(0, 30)));
        end
        default: begin
          write_reg(pca_pkg::REG_MIN_GAP, 16'($urandom_range(0, 6)));
          write_reg(pca_pkg::REG_HOLDOFF, 16'($urandom_range(0, 25)));
          write_reg(pca_pkg::REG_KEEPALIVE, 16'($urandom_range(0, 40)));
          write_reg(REG_UNUSED, 16'($urandom));
        end
      endcase
      repeat (72) begin
        c = ($urandom_range(0, 1) == 1) ? pca_pkg::CMD_TICK : pca_pkg::CMD_POST;
        send_request(c, 2'($urandom_range(0, 3)), ($urandom_range(0, 3) == 0),
                     (phase == 1) ? 0 : draw_gap(send_calm), 1'b0, NO_RESULT);
      end
    end

    in_tvalid <= 1'b0;
    while (grants_due.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("priority_command_arbiter_holdoff_test: PASS");
    end else begin
      $display("priority_command_arbiter_holdoff_test: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
